// File: sv/mtri_pkg.sv
`timescale 1ns / 1ps
// mtri_pkg: shared constants, opcode and state types for the morton tile range index
// no dependencies; compile first
package mtri_pkg;

    localparam int DEF_TABLE_DEPTH  = 256;
    localparam int DEF_DEEPEST_ZOOM = 20;

    localparam int OP_W    = 2;
    localparam int COORD_W = 20;
    localparam int ZOOM_W  = 5;
    localparam int DEF_CW  = $clog2(DEF_TABLE_DEPTH + 1);

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ENC
    } t_state;

    // per-cycle command broadcast to every cell of the row
    typedef struct packed {
        logic ins;   // shift-insert the new key
        logic lat;   // latch the two query compares
    } t_cell_cmd;

endpackage

// File: sv/mtri_in_if.sv
`timescale 1ns / 1ps
// mtri_in_if: input beat channel (valid/ready plus item fields)
// depends on mtri_pkg
interface mtri_in_if;
    import mtri_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [COORD_W-1:0] tile_x_coord;
    logic [COORD_W-1:0] tile_y_coord;
    logic [ZOOM_W-1:0]  zoom_level;
    logic               point_visible;

    modport source (
        output valid, opcode, tile_x_coord, tile_y_coord, zoom_level, point_visible,
        input  ready
    );
    modport sink (
        input  valid, opcode, tile_x_coord, tile_y_coord, zoom_level, point_visible,
        output ready
    );
endinterface

// File: sv/mtri_out_if.sv
`timescale 1ns / 1ps
// mtri_out_if: result beat channel (valid/ready plus result fields)
// depends on mtri_pkg
interface mtri_out_if #(
    parameter int CW = mtri_pkg::DEF_CW
);
    logic          valid;
    logic          ready;
    logic          status;
    logic [CW-1:0] range_start;
    logic [CW-1:0] range_end;
    logic [CW-1:0] entries_held;

    modport source (
        output valid, status, range_start, range_end, entries_held,
        input  ready
    );
    modport sink (
        input  valid, status, range_start, range_end, entries_held,
        output ready
    );
endinterface

// File: sv/morton_tile_range_index_top.sv
`timescale 1ns / 1ps
// morton_tile_range_index_top: sorted morton key table with tile range queries
// depends on mtri_pkg, mtri_in_if, mtri_out_if, mtri_cell, mtri_lbenc
//
// usage
//   i_item carries one beat per command: clear, insert a point, or query a tile.
//   o_result returns exactly one beat per accepted command, in order.
//   keys live in a row of TABLE_DEPTH cells kept in ascending order; an insert
//   compares the new key against every cell at once and the cells above the
//   insert point hand their key to the next cell up in the same cycle.
//   a query compares the tile prefix and the next prefix in every cell, then a
//   lower-bound encoder turns the two flag runs into indices.
// steps
//   clear and insert: accept, then commit to the cell row
//   query: accept, latch row compares, encode
//   one command is in flight at a time; the row compare and the encoder set this
// reset
//   i_rst_n low empties the table (count to zero) and drops any pending result;
//   cell contents are not cleared, slots at or above the count are never read
// stalls
//   a finished result sits in the output register while the next beat is
//   accepted; the following result waits in its last step until the register
//   frees, with the table left unchanged until it commits
module morton_tile_range_index_top #(
    parameter int TABLE_DEPTH  = mtri_pkg::DEF_TABLE_DEPTH,
    parameter int DEEPEST_ZOOM = mtri_pkg::DEF_DEEPEST_ZOOM
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mtri_in_if.sink    i_item,
    mtri_out_if.source o_result
);
    import mtri_pkg::*;

    localparam int KW  = 2 * DEEPEST_ZOOM;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int SHW = $clog2(KW + 1);
    localparam int XW  = (DEEPEST_ZOOM > COORD_W) ? DEEPEST_ZOOM : COORD_W;

    // x in even bits, y in odd bits, low DEEPEST_ZOOM bits of each coordinate
    function automatic logic [KW-1:0] interleave(
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y
    );
        logic [XW-1:0] xe;
        logic [XW-1:0] ye;
        logic [KW-1:0] k;
        xe = XW'(x);
        ye = XW'(y);
        k  = '0;
        for (int j = 0; j < DEEPEST_ZOOM; j++) begin
            k[2*j]   = xe[j];
            k[2*j+1] = ye[j];
        end
        return k;
    endfunction

    // state
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic          r_out_valid, n_out_valid;

    // captured command
    t_opcode       r_op;
    logic          r_vis;
    logic          r_empty;     // query outside the tile range or zoom too deep
    logic [KW-1:0] r_new_key;
    logic [KW-1:0] r_first;
    logic [KW:0]   r_next;

    // result register
    logic          r_status, n_status;
    logic [CW-1:0] r_rs, n_rs;
    logic [CW-1:0] r_re, n_re;
    logic [CW-1:0] r_held, n_held;
    logic          load;

    logic          accept;
    logic          slot_free;
    t_cell_cmd     cmd;

    // query prefix prep on the incoming beat
    logic [KW-1:0]  q_key;
    logic [SHW-1:0] q_sh;
    logic           q_empty;

    assign q_key   = interleave(i_item.tile_x_coord, i_item.tile_y_coord);
    assign q_sh    = SHW'(2 * (DEEPEST_ZOOM - int'(i_item.zoom_level)));
    assign q_empty = (int'(i_item.zoom_level) > DEEPEST_ZOOM)
                  || ((i_item.tile_x_coord >> i_item.zoom_level) != '0)
                  || ((i_item.tile_y_coord >> i_item.zoom_level) != '0);

    assign i_item.ready = (r_state == ST_IDLE);
    assign accept       = i_item.valid && i_item.ready;
    assign slot_free    = !r_out_valid || o_result.ready;

    // cell row
    logic [KW-1:0]          w_key [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_gt;
    logic [TABLE_DEPTH-1:0] w_lt_first;
    logic [TABLE_DEPTH-1:0] w_lt_next;

    for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
        logic [KW-1:0] prev_key;
        logic          prev_gt;
        if (i == 0) begin : g_head
            assign prev_key = r_new_key;
            assign prev_gt  = 1'b0;
        end else begin : g_body
            assign prev_key = w_key[i-1];
            assign prev_gt  = w_gt[i-1];
        end
        mtri_cell #(
            .KW(KW)
        ) u_cell (
            .i_clk      (i_clk),
            .i_cmd      (cmd),
            .i_live     (CW'(i) < r_count),
            .i_at_end   (CW'(i) == r_count),
            .i_new_key  (r_new_key),
            .i_first    (r_first),
            .i_next     (r_next),
            .i_prev_key (prev_key),
            .i_prev_gt  (prev_gt),
            .o_key      (w_key[i]),
            .o_gt       (w_gt[i]),
            .o_lt_first (w_lt_first[i]),
            .o_lt_next  (w_lt_next[i])
        );
    end

    logic [CW-1:0] enc_first;
    logic [CW-1:0] enc_next;

    mtri_lbenc #(
        .DEPTH(TABLE_DEPTH),
        .CW   (CW)
    ) u_enc_first (
        .i_lt  (w_lt_first),
        .o_idx (enc_first)
    );

    mtri_lbenc #(
        .DEPTH(TABLE_DEPTH),
        .CW   (CW)
    ) u_enc_next (
        .i_lt  (w_lt_next),
        .o_idx (enc_next)
    );

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // command capture and result register, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op      <= t_opcode'(i_item.opcode);
            r_vis     <= i_item.point_visible;
            r_empty   <= q_empty;
            r_new_key <= q_key;
            r_first   <= q_key << q_sh;
            r_next    <= {1'b0, q_key << q_sh} + ((KW + 1)'(1) << q_sh);
        end
        if (load) begin
            r_status <= n_status;
            r_rs     <= n_rs;
            r_re     <= n_re;
            r_held   <= n_held;
        end
    end

    // next state and outputs
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        load     = 1'b0;
        n_status = 1'b0;
        n_rs     = '0;
        n_re     = '0;
        n_held   = r_count;
        cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (r_op == OP_QUERY) begin
                    cmd.lat = 1'b1;
                    n_state = ST_ENC;
                end else if (slot_free) begin
                    load    = 1'b1;
                    n_state = ST_IDLE;
                    unique case (r_op)
                        OP_CLEAR: begin
                            n_count = '0;
                            n_held  = '0;
                        end
                        OP_INSERT: begin
                            if (r_vis) begin
                                if (int'(r_count) >= TABLE_DEPTH) begin
                                    n_status = 1'b1;
                                end else begin
                                    cmd.ins = 1'b1;
                                    n_count = r_count + CW'(1);
                                    n_held  = r_count + CW'(1);
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ENC: begin
                if (slot_free) begin
                    load    = 1'b1;
                    n_rs    = r_empty ? r_count : enc_first;
                    n_re    = r_empty ? r_count : enc_next;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid && !o_result.ready;
        if (load) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.status       = r_status;
    assign o_result.range_start  = r_rs;
    assign o_result.range_end    = r_re;
    assign o_result.entries_held = r_held;

`ifndef NO_ASSERTIONS
    // the table never holds more keys than it has cells
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= TABLE_DEPTH)
        else $error("entry count above table depth");

    // a committed insert grows the table by exactly one key
    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && cmd.ins) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insert did not add one entry");

    // a query latch is always followed by the encode step
    a_query_enc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && r_op == OP_QUERY) |=> (r_state == ST_ENC))
        else $error("query skipped the encode step");

    // a pending result never reports a range that runs backwards
    a_range_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_rs <= r_re))
        else $error("range start beyond range end");
`endif

endmodule

// File: sv/mtri_cell.sv
`timescale 1ns / 1ps
// mtri_cell: one slot of the sorted key row, shifts toward higher index on insert
// depends on mtri_pkg
module mtri_cell #(
    parameter int KW = 2 * mtri_pkg::DEF_DEEPEST_ZOOM
) (
    input  logic                i_clk,
    input  mtri_pkg::t_cell_cmd i_cmd,
    input  logic                i_live,      // slot holds a key
    input  logic                i_at_end,    // slot is the first free one
    input  logic [KW-1:0]       i_new_key,
    input  logic [KW-1:0]       i_first,
    input  logic [KW:0]         i_next,
    input  logic [KW-1:0]       i_prev_key,
    input  logic                i_prev_gt,
    output logic [KW-1:0]       o_key,
    output logic                o_gt,
    output logic                o_lt_first,
    output logic                o_lt_next
);
    import mtri_pkg::*;

    logic [KW-1:0] r_key;
    logic          r_lt_first;
    logic          r_lt_next;

    assign o_gt       = i_live && (r_key > i_new_key);
    assign o_key      = r_key;
    assign o_lt_first = r_lt_first;
    assign o_lt_next  = r_lt_next;

    always_ff @(posedge i_clk) begin
        if (i_cmd.ins) begin
            if (i_prev_gt) begin
                r_key <= i_prev_key;
            end else if (o_gt || i_at_end) begin
                r_key <= i_new_key;
            end
        end
        if (i_cmd.lat) begin
            r_lt_first <= i_live && (r_key < i_first);
            r_lt_next  <= i_live && ({1'b0, r_key} < i_next);
        end
    end

endmodule

// File: sv/mtri_lbenc.sv
`timescale 1ns / 1ps
// mtri_lbenc: turns the prefix of below-bound flags into the lower-bound index
// no package dependencies; used by the top level
module mtri_lbenc #(
    parameter int DEPTH = 256,
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic [DEPTH-1:0] i_lt,
    output logic [CW-1:0]    o_idx
);
    logic [DEPTH:0] lt_ext;

    assign lt_ext = {1'b0, i_lt};

    // flags form a run of ones from index 0; the run's far edge gives the count
    always_comb begin
        o_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (lt_ext[i] && !lt_ext[i+1]) begin
                o_idx = o_idx | CW'(i + 1);
            end
        end
    end

endmodule
